@@ rtl/core/backlight_fade_timeout_ctrl_unit_macros.svh @@
// Assertion macros for the backlight controller RTL.
`ifndef BACKLIGHT_FADE_TIMEOUT_CTRL_UNIT_MACROS_SVH
`define BACKLIGHT_FADE_TIMEOUT_CTRL_UNIT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define BFTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define BFTC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/bftc_pkg.sv @@
// Package for the backlight controller: codes, widths, brightness table.
`timescale 1ns / 1ps
package bftc_pkg;

  localparam int IdleCountBitsDef = 16;
  localparam int TimeoutW         = 16;
  localparam int BrightW          = 8;
  localparam int LevelW           = 3;
  localparam int InDataW          = 8;
  localparam int OutDataW         = 16;

  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd100;
  localparam logic [LevelW-1:0]   LevelReset   = 3'd7;
  localparam logic [BrightW-1:0]  BrightReset  = 8'd255;
  localparam logic [BrightW-1:0]  MinStep      = 8'd2;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_LIGHT = 2'd1,
    ACT_PROX  = 2'd2,
    ACT_TOUCH = 2'd3
  } action_t;

  typedef logic [BrightW-1:0] bright_t;

  function automatic bright_t level_target(input logic [LevelW-1:0] level);
    bright_t t;
    unique case (level)
      3'd0:    t = 8'd45;
      3'd1:    t = 8'd75;
      3'd2:    t = 8'd105;
      3'd3:    t = 8'd135;
      3'd4:    t = 8'd165;
      3'd5:    t = 8'd195;
      3'd6:    t = 8'd225;
      default: t = 8'd255;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/core/backlight_fade_timeout_ctrl_unit.sv @@
// Backlight controller: fade ramp, proximity turn-on, idle timeout turn-off.
// An accepted item waits in the input stage register, its result in the output register.
// Throughput: one item per cycle unless out_tready stalls a full output register;
// the state update is one short pass of logic.
// Reset (rst_n low, synchronous): both stages empty, timeout 100, level 7,
// brightness and last written value 255, lit, proximity off, idle count clear.
`timescale 1ns / 1ps
module backlight_fade_timeout_ctrl_unit #(
  parameter int IDLE_COUNT_BITS = bftc_pkg::IdleCountBitsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [2:0] sensor_value, [3] touch_pressed, [7:4] zero
  input  logic [bftc_pkg::InDataW-1:0]  in_tdata,
  // [1:0] action
  input  logic [1:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] brightness_out, [8] write_strobe, [9] input_enable, [15:10] zero
  output logic [bftc_pkg::OutDataW-1:0] out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bftc_pkg::TimeoutW-1:0] cfg_data
);
  import bftc_pkg::*;

  `include "backlight_fade_timeout_ctrl_unit_macros.svh"

  localparam int CmpW = (IDLE_COUNT_BITS > TimeoutW) ? IDLE_COUNT_BITS : TimeoutW;
  localparam logic [IDLE_COUNT_BITS-1:0] CountMax = {IDLE_COUNT_BITS{1'b1}};

  // input stage
  logic               s1_v_r;
  action_t            s1_action_r;
  logic [LevelW-1:0]  s1_sensor_r;
  logic               s1_press_r;
  logic               advance;

  // block state
  logic [TimeoutW-1:0]        timeout_r;
  logic [LevelW-1:0]          level_r, level_nxt;
  logic                       prox_r, prox_nxt;
  logic                       lit_r, lit_nxt;
  bright_t                    cur_r, cur_nxt;
  bright_t                    last_r, last_nxt;
  logic                       counting_r, counting_nxt;
  logic [IDLE_COUNT_BITS-1:0] idle_r, idle_nxt;
  logic                       strobe_nxt;

  // output stage
  logic    out_v_r;
  bright_t out_bright_r;
  logic    out_strobe_r;
  logic    out_enable_r;

  bright_t tgt, gap, step, ramped;
  bright_t drive1;
  logic    wrote1, wrote2;

  assign advance   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || advance;
  assign cfg_ready = 1'b1;

  // fade step toward the table target
  always_comb begin
    tgt = level_target(level_r);
    gap = (cur_r > tgt) ? (cur_r - tgt) : (tgt - cur_r);
    step = gap >> 1;
    if (step == '0) begin
      step = MinStep;
    end
    if (cur_r == tgt || step > gap) begin
      ramped = tgt;
    end else if (cur_r > tgt) begin
      ramped = cur_r - step;
    end else begin
      ramped = cur_r + step;
    end
  end

  always_comb begin
    level_nxt    = level_r;
    prox_nxt     = prox_r;
    lit_nxt      = lit_r;
    cur_nxt      = cur_r;
    last_nxt     = last_r;
    counting_nxt = counting_r;
    idle_nxt     = idle_r;
    strobe_nxt   = 1'b0;
    drive1       = last_r;
    wrote1       = 1'b0;
    wrote2       = 1'b0;
    case (s1_action_r)
      ACT_LIGHT: level_nxt = s1_sensor_r;
      ACT_PROX:  prox_nxt  = s1_sensor_r[0];
      ACT_TOUCH: begin
        counting_nxt = 1'b1;
        idle_nxt     = '0;
      end
      default: begin
        cur_nxt = ramped;
        if (lit_r != prox_r) begin
          if (!lit_r) begin
            lit_nxt = 1'b1;
          end else if (timeout_r != '0) begin
            if (!counting_r) begin
              counting_nxt = 1'b1;
              idle_nxt     = '0;
            end else begin
              if (idle_r != CountMax) begin
                idle_nxt = idle_r + 1'b1;
              end
              if (CmpW'(idle_nxt) > CmpW'(timeout_r)) begin
                lit_nxt = 1'b0;
              end
            end
          end
        end else begin
          counting_nxt = 1'b0;
          idle_nxt     = '0;
        end
        drive1 = lit_nxt ? ramped : '0;
        wrote1 = (drive1 != last_r);
        // wake on a held press; the panel sees off then on within one item
        if (!lit_nxt && s1_press_r) begin
          lit_nxt = 1'b1;
          wrote2  = (ramped != drive1);
          last_nxt = ramped;
        end else begin
          last_nxt = drive1;
        end
        strobe_nxt = wrote1 || wrote2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      timeout_r  <= TimeoutReset;
      level_r    <= LevelReset;
      prox_r     <= 1'b0;
      lit_r      <= 1'b1;
      cur_r      <= BrightReset;
      last_r     <= BrightReset;
      counting_r <= 1'b0;
      idle_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
      if (in_tvalid && in_tready) begin
        s1_v_r <= 1'b1;
      end else if (advance) begin
        s1_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r    <= 1'b1;
        level_r    <= level_nxt;
        prox_r     <= prox_nxt;
        lit_r      <= lit_nxt;
        cur_r      <= cur_nxt;
        last_r     <= last_nxt;
        counting_r <= counting_nxt;
        idle_r     <= idle_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_action_r <= action_t'(in_tuser);
      s1_sensor_r <= in_tdata[LevelW-1:0];
      s1_press_r  <= in_tdata[LevelW];
    end
    if (advance) begin
      out_bright_r <= last_nxt;
      out_strobe_r <= strobe_nxt;
      out_enable_r <= (last_nxt != '0);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OutDataW - BrightW - 2){1'b0}}, out_enable_r, out_strobe_r,
                       out_bright_r};

  `BFTC_ASSERT(a_prox_turn_on,
    advance && s1_action_r == ACT_TICK && !lit_r && prox_r |=> lit_r,
    "tick with proximity did not turn the display on")
  `BFTC_ASSERT(a_zero_timeout_stays_lit,
    advance && lit_r && timeout_r == '0 |=> lit_r,
    "display turned off with timeout disabled")
  `BFTC_ASSERT(a_non_tick_no_write,
    advance && s1_action_r != ACT_TICK |=> !out_strobe_r && $stable(last_r),
    "non-tick item wrote the panel")
  `BFTC_ASSERT(a_stall_only_when_full,
    !in_tready |-> s1_v_r && out_v_r && !out_tready,
    "input stalled while a stage was free")

endmodule

@@ tb/tb_backlight_fade_timeout_ctrl_unit.sv @@
// Self-checking testbench for the backlight fade and idle timeout controller.
`timescale 1ns / 1ps
module tb_backlight_fade_timeout_ctrl_unit;
  import bftc_pkg::*;

  localparam int IDLE_BITS     = IdleCountBitsDef;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 11;
  localparam int PHASE_ITEMS   = 50;
  localparam int DIRECTED_ROWS = 28;

  localparam bright_t FADE_TARGET [8] = '{8'd45, 8'd75, 8'd105, 8'd135,
                                          8'd165, 8'd195, 8'd225, 8'd255};

  typedef struct packed {
    logic    enable;
    logic    strobe;
    bright_t level;
  } panel_word_t;

  typedef enum logic {ROW_EVENT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    action_t             act;
    logic [LevelW-1:0]   sens;
    logic                press;
    logic [TimeoutW-1:0] cfg_val;
    bit                  typed;
    panel_word_t         typed_word;
  } dir_row_t;

  localparam panel_word_t AT_RESET = '{enable: 1'b1, strobe: 1'b0, level: 8'd255};
  localparam panel_word_t NO_WORD  = '0;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic [1:0]          in_tuser = ACT_TICK;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [TimeoutW-1:0] cfg_data = '0;

  // Shadow state of the controller
  logic [TimeoutW-1:0]  fade_timeout;
  logic [LevelW-1:0]    light_lvl;
  logic                 prox_on;
  logic                 lit;
  bright_t              cur_level;
  bright_t              panel_level;
  logic                 idle_counting;
  logic [IDLE_BITS-1:0] idle_cnt;

  panel_word_t expected_panel_q[$];
  int          mismatches = 0;
  int          stall_cycles = 0;
  logic [15:0] ready_pattern = 16'hFFFF;
  int unsigned ready_cnt = 0;
  dir_row_t    directed_tbl [DIRECTED_ROWS];

  backlight_fade_timeout_ctrl_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic void reset_backlight_state();
    fade_timeout  = TimeoutReset;
    light_lvl     = LevelReset;
    prox_on       = 1'b0;
    lit           = 1'b1;
    cur_level     = BrightReset;
    panel_level   = BrightReset;
    idle_counting = 1'b0;
    idle_cnt      = '0;
  endfunction

  // Write the panel only when the value changes; report whether it did.
  function automatic logic push_panel();
    bright_t v;
    v = lit ? cur_level : '0;
    if (v == panel_level) return 1'b0;
    panel_level = v;
    return 1'b1;
  endfunction

  function automatic panel_word_t backlight_next(action_t act, logic [LevelW-1:0] sens,
                                                 logic press);
    panel_word_t w;
    bright_t     tgt;
    bright_t     gap;
    bright_t     stp;
    logic        wrote;
    wrote = 1'b0;
    case (act)
      ACT_LIGHT: light_lvl = sens;
      ACT_PROX:  prox_on = sens[0];
      ACT_TOUCH: begin
        idle_counting = 1'b1;
        idle_cnt      = '0;
      end
      ACT_TICK: begin
        tgt = FADE_TARGET[light_lvl];
        if (cur_level != tgt) begin
          gap = (cur_level > tgt) ? cur_level - tgt : tgt - cur_level;
          stp = gap >> 1;
          if (stp == '0) stp = MinStep;
          if (stp > gap) cur_level = tgt;
          else if (cur_level > tgt) cur_level = cur_level - stp;
          else cur_level = cur_level + stp;
        end
        if (lit != prox_on) begin
          if (!lit) begin
            lit = 1'b1;
          end else if (fade_timeout != '0) begin
            if (!idle_counting) begin
              idle_counting = 1'b1;
              idle_cnt      = '0;
            end else begin
              if (idle_cnt != '1) idle_cnt = idle_cnt + 1'b1;
              if (idle_cnt > fade_timeout) lit = 1'b0;
            end
          end
        end else begin
          idle_counting = 1'b0;
          idle_cnt      = '0;
        end
        wrote = push_panel();
        // a pressed touch wakes the panel, even on the tick that turned it off
        if (!lit && press) begin
          lit = 1'b1;
          if (push_panel()) wrote = 1'b1;
        end
      end
    endcase
    w.level  = panel_level;
    w.strobe = wrote;
    w.enable = (panel_level != '0);
    return w;
  endfunction

  task automatic send_event(action_t act, logic [LevelW-1:0] sens, logic press,
                            bit typed, panel_word_t typed_word);
    panel_word_t predicted;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {4'b0000, press, sens};
    do @(posedge clk); while (!in_tready);
    predicted = backlight_next(act, sens, press);
    expected_panel_q.push_back(typed ? typed_word : predicted);
  endtask

  task automatic idle_sender(int n);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Hold the sender until every result is back, then let the pipeline empty.
  task automatic settle_block();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_panel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(logic [TimeoutW-1:0] v);
    settle_block();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    fade_timeout = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Receiver: 16-bit ready pattern, redrawn at ready_cnt[5:0] == 0, bit 0 always set.
  always @(negedge clk) begin
    ready_cnt <= ready_cnt + 1;
    if (ready_cnt[5:0] == 6'd0)
      ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    out_tready <= ready_pattern[ready_cnt[3:0]];
  end

  always @(posedge clk) begin : result_check
    panel_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_panel_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with nothing expected, got 0x%0h", $time, out_tdata);
      end else begin
        want = expected_panel_q.pop_front();
        check_field("brightness_out", want.level, out_tdata[7:0]);
        check_field("write_strobe", want.strobe, out_tdata[8]);
        check_field("input_enable", want.enable, out_tdata[9]);
        check_field("tdata padding", 0, out_tdata[15:10]);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("backlight_fade_timeout_ctrl_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [TimeoutW-1:0] tmo;
    action_t             act;
    int                  pick;
    int                  burst_left;
    bit                  gappy;

    directed_tbl = '{
      // non-tick items and a still tick right after reset
      '{ROW_EVENT, ACT_LIGHT, 3'd7, 1'b1, 16'd0, 1'b1, AT_RESET},
      '{ROW_EVENT, ACT_PROX,  3'd6, 1'b1, 16'd0, 1'b1, AT_RESET},
      '{ROW_EVENT, ACT_TOUCH, 3'd7, 1'b0, 16'd0, 1'b1, AT_RESET},
      '{ROW_EVENT, ACT_TICK,  3'd7, 1'b0, 16'd0, 1'b1, AT_RESET},
      // zero timeout: ramp all the way down to the lowest target, small steps last
      '{ROW_CFG,   ACT_TICK,  3'd0, 1'b0, 16'd0, 1'b0, NO_WORD},
      '{ROW_EVENT, ACT_LIGHT, 3'd0, 1'b0, 16'd0, 1'b0, NO_WORD},
      '{ROW_EVENT, ACT_TICK,  3'd0, 1'b0, 16'd0, 1'b0, NO_WORD},
      '{ROW_EVENT, ACT_TICK,  3'd5, 1'b1, 16'd0, 1'b0, NO_WORD},
      '{ROW_EVENT, ACT_TICK,  3'd2, 1'b0, 16'd0, 1'b0, NO_WORD},
      '{ROW_EVENT, ACT_TICK,  3'd7, 1'b1, 16'd0, 1'b0, NO_WORD},
      '{ROW_EVENT, ACT_TICK,  3'd0, 1'b0, 16'd0, 1'b0, NO_WORD},
      '{ROW_EVENT, ACT_TICK,  3'd1, 1'b1, 16'd0, 1'b0, NO_WORD},
      '{ROW_EVENT, ACT_TICK,  3'd0, 1'b0, 16'd0, 1'b0, NO_WORD},
      '{ROW_EVENT, ACT_TICK,  3'd4, 1'b1, 16'd0, 1'b0, NO_WORD},
      '{ROW_EVENT, ACT_TICK,  3'd0, 1'b0, 16'd0, 1'b0, NO_WORD},
      // shortest timeout: turn off, wake on press, off and wake on one tick
      '{ROW_CFG,   ACT_TICK,  3'd0, 1'b0, 16'd1, 1'b0, NO_WORD},
      '{ROW_EVENT, ACT_TICK,  3'd0, 1'b0, 16'd0, 1'b0, NO_WORD},
      '{ROW_EVENT, ACT_TICK,  3'd0, 1'b1, 16'd0, 1'b0, NO_WORD},
      '{ROW_EVENT, ACT_TICK,  3'd0, 1'b0, 16'd0, 1'b0, NO_WORD},
      '{ROW_EVENT, ACT_TICK,  3'd0, 1'b0, 16'd0, 1'b0, NO_WORD},
      '{ROW_EVENT, ACT_TICK,  3'd0, 1'b1, 16'd0, 1'b0, NO_WORD},
      '{ROW_EVENT, ACT_TICK,  3'd0, 1'b0, 16'd0, 1'b0, NO_WORD},
      // proximity turns the panel back on, then matching state stops the count
      '{ROW_EVENT, ACT_PROX,  3'd1, 1'b0, 16'd0, 1'b0, NO_WORD},
      '{ROW_EVENT, ACT_TICK,  3'd0, 1'b0, 16'd0, 1'b0, NO_WORD},
      '{ROW_EVENT, ACT_TICK,  3'd0, 1'b0, 16'd0, 1'b0, NO_WORD},
      '{ROW_EVENT, ACT_LIGHT, 3'd4, 1'b0, 16'd0, 1'b0, NO_WORD},
      '{ROW_CFG,   ACT_TICK,  3'd0, 1'b0, 16'hFFFF, 1'b0, NO_WORD},
      '{ROW_EVENT, ACT_TICK,  3'd5, 1'b1, 16'd0, 1'b0, NO_WORD}
    };

    reset_backlight_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_tbl[r]) begin
      if (directed_tbl[r].kind == ROW_CFG)
        write_timeout(directed_tbl[r].cfg_val);
      else
        send_event(directed_tbl[r].act, directed_tbl[r].sens, directed_tbl[r].press,
                   directed_tbl[r].typed, directed_tbl[r].typed_word);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: tmo = TimeoutReset;
        1: tmo = 16'd1;
        2: tmo = 16'd0;
        3: tmo = 16'hFFFF;
        default: begin
          pick = $urandom_range(0, 3);
          if (pick < 2) tmo = 16'($urandom_range(1, 6));
          else if (pick == 2) tmo = 16'($urandom_range(7, 40));
          else tmo = 16'($urandom);
        end
      endcase
      write_timeout(tmo);
      gappy      = (ph % 3 != 1);
      burst_left = $urandom_range(1, 16);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) act = ACT_TICK;
        else if (pick < 60) act = ACT_LIGHT;
        else if (pick < 80) act = ACT_PROX;
        else act = ACT_TOUCH;
        send_event(act, 3'($urandom_range(0, 7)), ($urandom_range(0, 3) == 0), 1'b0, NO_WORD);
        if (gappy) begin
          burst_left--;
          if (burst_left == 0) begin
            idle_sender($urandom_range(1, 8));
            burst_left = $urandom_range(1, 16);
          end
        end
      end
    end

    settle_block();
    if (mismatches == 0 && expected_panel_q.size() == 0)
      $display("backlight_fade_timeout_ctrl_unit regression: pass");
    else
      $display("backlight_fade_timeout_ctrl_unit regression: fail");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/bftc_pkg.sv
rtl/core/backlight_fade_timeout_ctrl_unit.sv
tb/tb_backlight_fade_timeout_ctrl_unit.sv
